@@ hdl/sacl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the set-associative cache unit.
// No dependencies.
package sacl_pkg;

    // default storage sizes
    localparam int unsigned DEF_MAX_LINES       = 8192;
    localparam int unsigned DEF_MAX_CACHE_WORDS = 16384;
    localparam int unsigned DEF_MEM_WORDS       = 65536;
    localparam int unsigned DEF_STAMP_BITS      = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_BLOCK    = 2'd1;
    localparam logic [1:0] CFG_WAYS     = 2'd2;

    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned SET_W      = 13;   // widest set index
    localparam logic [31:0] ADDR_LIMIT_MASK = 32'd1048575;

    // cache geometry derived from the configuration registers
    typedef struct packed {
        logic [1:0] lg_ways;    // log2 ways
        logic [2:0] off_bits;   // log2 words per line
        logic [3:0] idx_bits;   // log2 sets
        logic [4:0] tag_shift;  // off_bits + idx_bits
    } t_geom;

    // log2 of a power of two up to 64
    function automatic logic [2:0] f_lg(input logic [CFG_DATA_W-1:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < CFG_DATA_W; i++) begin
            if (v[i]) r = 3'(i);
        end
        return r;
    endfunction

    // exactly one bit set
    function automatic logic f_pow2(input logic [CFG_DATA_W-1:0] v);
        return (v != '0) && ((v & (v - 7'd1)) == '0);
    endfunction

endpackage

@@ hdl/sacl_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sacl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/sacl_cfg.sv @@
`timescale 1ns / 1ps
// Configuration registers of the cache unit and the geometry derived from them.
// Depends on sacl_pkg.
module sacl_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sacl_pkg::t_geom                  o_geom,
    output logic                             o_clear
);
    import sacl_pkg::*;

    logic [2:0] r_lg_cap, r_lg_blk;
    logic [1:0] r_lg_ways;
    logic       r_clear;
    logic       legal;

    assign o_cfg_ready = 1'b1;

    // legal value check per register
    always_comb begin
        legal = 1'b0;
        unique case (i_cfg_index)
            CFG_CAPACITY: legal = f_pow2(i_cfg_data) && (i_cfg_data >= 7'd2);
            CFG_BLOCK:    legal = f_pow2(i_cfg_data) && (i_cfg_data >= 7'd8);
            CFG_WAYS:     legal = f_pow2(i_cfg_data) && (i_cfg_data <= 7'd8);
            default:      legal = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_cap  <= 3'd3;
            r_lg_blk  <= 3'd4;
            r_lg_ways <= 2'd2;
            r_clear   <= 1'b0;
        end else begin
            // legal is never set for the unused index
            r_clear <= i_cfg_valid && legal;
            if (i_cfg_valid && legal) begin
                unique case (i_cfg_index)
                    CFG_CAPACITY: r_lg_cap  <= f_lg(i_cfg_data);
                    CFG_BLOCK:    r_lg_blk  <= f_lg(i_cfg_data);
                    CFG_WAYS:     r_lg_ways <= 2'(f_lg(i_cfg_data));
                    default:      ;
                endcase
            end
        end
    end

    // sets = 2^(lg_cap + 10 - lg_blk - lg_ways), words per line = 2^(lg_blk - 2)
    always_comb begin
        o_geom.lg_ways   = r_lg_ways;
        o_geom.off_bits  = r_lg_blk - 3'd2;
        o_geom.idx_bits  = 4'(4'(r_lg_cap) + 4'd10 - 4'(r_lg_blk) - 4'(r_lg_ways));
        o_geom.tag_shift = 5'(o_geom.off_bits) + 5'(o_geom.idx_bits);
    end

    assign o_clear = r_clear;
endmodule

@@ hdl/set_assoc_cache_lru_writeback_unit.sv @@
`timescale 1ns / 1ps
// Set-associative LRU cache with write-back to its own backing memory.
// An access scans the ways, updates the metadata, writes back a victim and fills the
// line where needed, then accesses the word and returns the result. One item at a time:
// the next transaction is taken once the result is registered.
// Reset: a sweep loads backing memory and clears tags; a legal config write starts a
// tag clear. Input stalls during sweeps.
module set_assoc_cache_lru_writeback_unit #(
    parameter int unsigned MAX_LINES       = sacl_pkg::DEF_MAX_LINES,
    parameter int unsigned MAX_CACHE_WORDS = sacl_pkg::DEF_MAX_CACHE_WORDS,
    parameter int unsigned MEM_WORDS       = sacl_pkg::DEF_MEM_WORDS,
    parameter int unsigned STAMP_BITS      = sacl_pkg::DEF_STAMP_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [31:0]                     i_addr,
    input  logic [31:0]                     i_write_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [31:0]                     o_read_word,
    output logic                            o_hit,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sacl_pkg::*;

    localparam int unsigned LW  = $clog2(MAX_LINES);
    localparam int unsigned CW  = $clog2(MAX_CACHE_WORDS);
    localparam int unsigned MAW = $clog2(MEM_WORDS);
    localparam int unsigned SXW = (LW + 4 > CW) ? LW + 4 : CW;
    localparam int unsigned SW  = (MAW > LW) ? MAW : LW;
    localparam int unsigned MW  = 1 + 32 + STAMP_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_META  = 3'd2;
    localparam logic [2:0] S_SPILL = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    function automatic logic [LW-1:0] f_line(input logic [SET_W-1:0] s,
                                             input logic [2:0] w, input logic [1:0] lw);
        logic [15:0] t;
        t = ({3'b0, s} << lw) | {13'b0, w};
        return t[LW-1:0];
    endfunction

    function automatic logic [CW-1:0] f_slot(input logic [LW-1:0] ln,
                                             input logic [3:0] c, input logic [2:0] off);
        logic [SXW-1:0] t;
        t = (SXW'(ln) << off) | SXW'(c);
        return t[CW-1:0];
    endfunction

    function automatic logic [MAW-1:0] f_maddr(input logic [MAW-1:0] base,
                                               input logic [3:0] c, input logic [2:0] off);
        logic [MAW-1:0] m;
        m = ~({MAW{1'b1}} << off);
        return (base & ~m) | MAW'(c);
    endfunction

    t_geom g;
    logic  cfg_clear;

    sacl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (g),
        .o_clear     (cfg_clear)
    );

    // control state
    logic [2:0]        r_state;
    logic              r_clr_lines, r_clr_mem;
    logic [SW-1:0]     r_sweep;
    logic [2:0]        r_w;
    logic [4:0]        r_c;
    logic              r_mfound, r_mvalid, r_ifound;
    logic              r_out_valid;
    // item payload
    logic              r_op;
    logic [31:0]       r_addr, r_wdata, r_tag, r_btag;
    logic [SET_W-1:0]  r_set;
    logic [LW-1:0]     r_mline, r_iline, r_bline, r_line;
    logic [STAMP_BITS-1:0] r_bstamp;
    logic              r_hit;
    logic [MAW-1:0]    r_back;
    logic [31:0]       r_out_word;
    logic              r_out_hit;

    logic              busy, in_acc, out_free;
    logic [31:0]       addr_sh;
    logic [SET_W-1:0]  set_in;
    logic [4:0]        wpl;
    logic [3:0]        off_mask, offset;
    logic [2:0]        nways_m1;

    // memory ports
    logic              meta_we, ctr_we, data_we, back_we;
    logic [LW-1:0]     meta_wa, meta_ra, ctr_wa;
    logic [MW-1:0]     meta_wd, meta_rd;
    logic [STAMP_BITS-1:0] ctr_wd, ctr_rd;
    logic [CW-1:0]     data_wa, data_ra;
    logic [31:0]       data_wd, data_rd, back_wd, back_rd;
    logic [MAW-1:0]    back_wa, back_ra;

    logic              rd_valid;
    logic [31:0]       rd_tag;
    logic [STAMP_BITS-1:0] rd_stamp;

    // decision at the end of the scan
    logic [LW-1:0]     dec_line;
    logic              dec_hit, dec_fill, dec_spill;
    logic [31:0]       back_full;

    // a pending tag clear blocks the input from the cycle after the register write
    assign busy     = r_clr_lines || r_clr_mem || cfg_clear;
    assign o_in_stall = !(r_state == S_IDLE && !busy);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign addr_sh  = i_addr >> g.off_bits;
    assign set_in   = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << g.idx_bits);
    assign wpl      = 5'd1 << g.off_bits;
    assign off_mask = 4'(wpl - 5'd1);
    assign offset   = r_addr[3:0] & off_mask;
    assign nways_m1 = 3'((4'd1 << g.lg_ways) - 4'd1);

    assign rd_valid = meta_rd[MW-1];
    assign rd_tag   = meta_rd[MW-2 -: 32];
    assign rd_stamp = meta_rd[STAMP_BITS-1:0];

    always_comb begin
        if (r_mfound) begin
            dec_line = r_mline; dec_hit = r_mvalid; dec_fill = !r_mvalid; dec_spill = 1'b0;
        end else if (r_ifound) begin
            dec_line = r_iline; dec_hit = 1'b0; dec_fill = 1'b1; dec_spill = 1'b0;
        end else begin
            dec_line = r_bline; dec_hit = 1'b0; dec_fill = 1'b1; dec_spill = 1'b1;
        end
    end

    // victim's original word address
    assign back_full = 32'(r_btag << g.tag_shift) | (32'(r_set) << g.off_bits);

    // metadata and stamp counter ports
    always_comb begin
        meta_ra = (r_state == S_IDLE) ? f_line(set_in, 3'd0, g.lg_ways)
                                      : f_line(r_set, r_w + 3'd1, g.lg_ways);
        meta_we = 1'b0;
        meta_wa = dec_line;
        meta_wd = {1'b1, r_tag, ctr_rd};
        ctr_we  = 1'b0;
        ctr_wa  = r_set[LW-1:0];
        ctr_wd  = ctr_rd + 1'b1;
        if (r_clr_lines) begin
            meta_we = 1'b1;
            meta_wa = r_sweep[LW-1:0];
            meta_wd = '0;
            ctr_we  = 1'b1;
            ctr_wa  = r_sweep[LW-1:0];
            ctr_wd  = '0;
        end else if (r_state == S_META) begin
            meta_we = 1'b1;
            ctr_we  = 1'b1;
        end
    end

    // line data and backing memory ports
    always_comb begin
        data_ra = f_slot(r_line, offset, g.off_bits);
        data_we = 1'b0;
        data_wa = f_slot(r_line, offset, g.off_bits);
        data_wd = r_wdata;
        back_ra = f_maddr(r_addr[MAW-1:0], r_c[3:0], g.off_bits);
        back_we = 1'b0;
        back_wa = f_maddr(r_back, r_c[3:0] - 4'd1, g.off_bits);
        back_wd = data_rd;
        if (r_state == S_SPILL) begin
            data_ra = f_slot(r_line, r_c[3:0], g.off_bits);
            back_we = (r_c != 5'd0);
        end
        if (r_state == S_FILL) begin
            data_we = (r_c != 5'd0);
            data_wa = f_slot(r_line, r_c[3:0] - 4'd1, g.off_bits);
            data_wd = back_rd;
        end
        if (r_state == S_ACC) data_we = r_op;
        if (r_clr_mem) begin
            back_we = 1'b1;
            back_wa = r_sweep[MAW-1:0];
            back_wd = 32'(r_sweep);
        end
    end

    // sweeps after reset and after geometry changes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_lines <= 1'b1;
            r_clr_mem   <= 1'b1;
            r_sweep     <= '0;
        end else if (cfg_clear) begin
            r_clr_lines <= 1'b1;
            r_sweep     <= '0;
        end else if (busy) begin
            r_sweep <= r_sweep + 1'b1;
            if (r_sweep == SW'(MAX_LINES - 1)) r_clr_lines <= 1'b0;
            if (r_sweep == SW'(MEM_WORDS - 1)) r_clr_mem <= 1'b0;
        end
    end

    // access sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w         <= '0;
            r_c         <= '0;
            r_mfound    <= 1'b0;
            r_ifound    <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_RESP) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_op;
                        r_addr   <= i_addr;
                        r_wdata  <= i_write_word;
                        r_set    <= set_in;
                        r_tag    <= i_addr >> g.tag_shift;
                        r_w      <= '0;
                        r_mfound <= 1'b0;
                        r_ifound <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_mfound && rd_tag == r_tag) begin
                        r_mfound <= 1'b1;
                        r_mline  <= f_line(r_set, r_w, g.lg_ways);
                        r_mvalid <= rd_valid;
                    end
                    if (!r_ifound && !rd_valid) begin
                        r_ifound <= 1'b1;
                        r_iline  <= f_line(r_set, r_w, g.lg_ways);
                    end
                    // least stamp, ties to the lowest way
                    if (r_w == 3'd0 || rd_stamp < r_bstamp) begin
                        r_bstamp <= rd_stamp;
                        r_bline  <= f_line(r_set, r_w, g.lg_ways);
                        r_btag   <= rd_tag;
                    end
                    if (r_w == nways_m1) r_state <= S_META;
                    else r_w <= r_w + 3'd1;
                end
                S_META: begin
                    r_line  <= dec_line;
                    r_hit   <= dec_hit;
                    r_back  <= back_full[MAW-1:0];
                    r_c     <= '0;
                    r_state <= dec_spill ? S_SPILL : (dec_fill ? S_FILL : S_ACC);
                end
                S_SPILL: begin
                    if (r_c == wpl) begin
                        r_c     <= '0;
                        r_state <= S_FILL;
                    end else r_c <= r_c + 5'd1;
                end
                S_FILL: begin
                    if (r_c == wpl) r_state <= S_ACC;
                    else r_c <= r_c + 5'd1;
                end
                S_ACC: r_state <= S_RESP;
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_op ? 32'd0 : data_rd;
                        r_out_hit   <= r_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_word = r_out_word;
    assign o_hit       = r_out_hit;

    // valid, tag and stamp per line
    sacl_ram #(.WIDTH(MW), .DEPTH(MAX_LINES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(meta_wd),
        .i_raddr(meta_ra), .o_rdata(meta_rd)
    );

    // stamp counter per set
    sacl_ram #(.WIDTH(STAMP_BITS), .DEPTH(MAX_LINES)) u_ctr (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(ctr_wa), .i_wdata(ctr_wd),
        .i_raddr(r_set[LW-1:0]), .o_rdata(ctr_rd)
    );

    // line words
    sacl_ram #(.WIDTH(32), .DEPTH(MAX_CACHE_WORDS)) u_data (
        .i_clk(i_clk), .i_we(data_we), .i_waddr(data_wa), .i_wdata(data_wd),
        .i_raddr(data_ra), .o_rdata(data_rd)
    );

    // backing word memory
    sacl_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_back (
        .i_clk(i_clk), .i_we(back_we), .i_waddr(back_wa), .i_wdata(back_wd),
        .i_raddr(back_ra), .o_rdata(back_rd)
    );
endmodule

@@ hdl/sacl_chk.sv @@
`timescale 1ns / 1ps
// Port-level checks for the cache unit, bound to the top level.
// Depends on set_assoc_cache_lru_writeback_unit.
module sacl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_word,
    input logic        o_hit
);
    // reset starts the memory sweep, so no transaction is taken right after
    a_rst_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one transaction in flight: accepting stalls the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_word) && $stable(o_hit))
        else $error("stalled result changed");
endmodule

bind set_assoc_cache_lru_writeback_unit sacl_chk u_chk (.*);

@@ tb/set_assoc_cache_lru_writeback_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_cache_lru_writeback_unit.
// Needs sacl_pkg and the unit; predicts each access result in a local cache model.
module set_assoc_cache_lru_writeback_unit_test;
    import sacl_pkg::*;

    localparam int unsigned NLINES   = DEF_MAX_LINES;
    localparam int unsigned NWORDS   = DEF_MAX_CACHE_WORDS;
    localparam int unsigned NMEM     = DEF_MEM_WORDS;
    localparam logic [1:0]  CFG_NONE = 2'd3;   // index with no register behind it
    localparam logic        OP_READ  = 1'b0;
    localparam logic        OP_WRITE = 1'b1;
    localparam int unsigned SETTLE   = 64;     // above the worst access latency
    localparam int unsigned WDOG_MAX = 200000; // covers the reset sweep

    typedef struct packed {
        logic [31:0] read_word;
        logic        hit;
    } t_access_result;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_op         = 1'b0;
    logic [31:0] i_addr       = '0;
    logic [31:0] i_write_word = '0;
    logic        i_out_stall  = 1'b1;
    logic        i_cfg_valid  = 1'b0;
    logic [1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_in_stall, o_out_valid, o_hit, o_cfg_ready;
    logic [31:0] o_read_word;

    set_assoc_cache_lru_writeback_unit dut (.*);

    // local copy of the cache and backing memory
    int unsigned cap_kb, blk_bytes, nways;
    bit          mdl_valid [NLINES];
    logic [31:0] mdl_tag   [NLINES];
    logic [31:0] mdl_stamp [NLINES];
    logic [31:0] mdl_count [NLINES];
    logic [31:0] mdl_words [NWORDS];
    logic [31:0] mdl_mem   [NMEM];

    t_access_result expected_results[$];
    int unsigned n_errors, n_sent, n_checked, n_hits, n_cfg;
    bit          no_idle;   // burst stretches with no gaps on either side

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned lg2(input int unsigned v);
        int unsigned n;
        n = 0;
        while (v > 1) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < NLINES; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_tag[i]   = '0;
            mdl_stamp[i] = '0;
            mdl_count[i] = '0;
        end
    endfunction

    function automatic void model_reset();
        cap_kb    = 8;
        blk_bytes = 16;
        nways     = 4;
        clear_lines();
        for (int i = 0; i < NWORDS; i++) mdl_words[i] = '0;
        for (int i = 0; i < NMEM; i++) mdl_mem[i] = 32'(i);
    endfunction

    function automatic void model_config(input logic [1:0] idx, input int unsigned val);
        case (idx)
            CFG_CAPACITY: begin
                if (!(val inside {2, 4, 8, 16, 32, 64})) return;
                cap_kb = val;
            end
            CFG_BLOCK: begin
                if (!(val inside {8, 16, 32, 64})) return;
                blk_bytes = val;
            end
            CFG_WAYS: begin
                if (!(val inside {1, 2, 4, 8})) return;
                nways = val;
            end
            default: return;
        endcase
        clear_lines();
    endfunction

    // copy a line between cache words and memory (to_mem: write-back)
    function automatic void move_line(input int unsigned ln, input int unsigned wpl,
                                      input logic [31:0] a, input bit to_mem);
        logic [31:0] base;
        int unsigned ws, ma;
        base = a & ADDR_LIMIT_MASK & 32'(NMEM - 1);
        base = base - (base % wpl);
        for (int unsigned i = 0; i < wpl; i++) begin
            ws = (ln * wpl + i) % NWORDS;
            ma = (base + i) & (NMEM - 1);
            if (to_mem) mdl_mem[ma] = mdl_words[ws];
            else        mdl_words[ws] = mdl_mem[ma];
        end
    endfunction

    function automatic t_access_result cache_access(input logic op, input logic [31:0] a,
                                                     input logic [31:0] d);
        int unsigned wpl, sets, offb, sh, set_i, first, ln, l, best;
        logic [31:0] tg, back;
        bit found;
        t_access_result r;
        wpl   = blk_bytes / 4;
        sets  = (cap_kb * 1024) / (blk_bytes * nways);
        offb  = lg2(wpl);
        sh    = offb + lg2(sets);
        set_i = (a >> offb) & (sets - 1);
        tg    = a >> sh;
        first = set_i * nways;
        found = 1'b0;
        r.hit = 1'b0;
        ln    = 0;
        // tag match, valid or not
        for (int unsigned w = 0; w < nways && !found; w++) begin
            l = (first + w) % NLINES;
            if (mdl_tag[l] == tg) begin
                ln = l;
                found = 1'b1;
                if (mdl_valid[l]) r.hit = 1'b1;
                else begin
                    move_line(l, wpl, a, 1'b0);
                    mdl_valid[l] = 1'b1;
                end
            end
        end
        // first empty way
        for (int unsigned w = 0; w < nways && !found; w++) begin
            l = (first + w) % NLINES;
            if (!mdl_valid[l]) begin
                ln = l;
                found = 1'b1;
                move_line(l, wpl, a, 1'b0);
                mdl_valid[l] = 1'b1;
                mdl_tag[l] = tg;
            end
        end
        // least stamp is evicted and always written back
        if (!found) begin
            best = first % NLINES;
            for (int unsigned w = 1; w < nways; w++) begin
                l = (first + w) % NLINES;
                if (mdl_stamp[l] < mdl_stamp[best]) best = l;
            end
            ln = best;
            back = (mdl_tag[best] << sh) | (32'(set_i) << offb);
            move_line(best, wpl, back, 1'b1);
            move_line(best, wpl, a, 1'b0);
            mdl_valid[best] = 1'b1;
            mdl_tag[best] = tg;
        end
        mdl_stamp[ln] = mdl_count[set_i % NLINES];
        mdl_count[set_i % NLINES] = mdl_count[set_i % NLINES] + 1;
        l = (ln * wpl + (a & (wpl - 1))) % NWORDS;
        if (op == OP_WRITE) begin
            mdl_words[l] = d;
            r.read_word = '0;
        end else begin
            r.read_word = mdl_words[l];
        end
        return r;
    endfunction

    function automatic int unsigned idle_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    // one access transaction; prediction is made in send order
    task automatic send_access(input logic op, input logic [31:0] a, input logic [31:0] d);
        int unsigned gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_addr       <= a;
        i_write_word <= d;
        expected_results.push_back(cache_access(op, a, d));
        n_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_config(idx, val);
        n_cfg++;
    endtask

    // mostly a small hot region so lines get reused, sometimes the full range
    function automatic logic [31:0] rand_addr();
        if ($urandom_range(0, 9) < 2) return $urandom;
        return 32'($urandom_range(0, 3)) << 20 | 32'($urandom_range(0, 2047))
               | 32'($urandom_range(0, 3)) << 14;
    endfunction

    task automatic random_phase(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, rand_addr(), $urandom);
        end
        no_idle = 1'b0;
    endtask

    // under reset geometry: 4 words per line, 128 sets, tag from bit 9 up
    task automatic test_reset_geometry();
        send_access(OP_READ, 32'h0, 32'h0);                    // tag match on invalid line
        send_access(OP_READ, 32'h1, 32'h0);                    // now a hit
        send_access(OP_WRITE, 32'h5, 32'hFFFF_FFFF);
        send_access(OP_READ, 32'h5, 32'h0);
        send_access(OP_READ, 32'hFFFF_FFFF, 32'h0);            // memory address masked
        send_access(OP_WRITE, 32'hFFFF_FFFE, 32'hA5A5_5A5A);
        send_access(OP_READ, 32'hFFFF_FFFE, 32'h0);
        // fill set 0 past its four ways, then read the evicted words back
        for (int unsigned k = 1; k <= 6; k++)
            send_access(OP_WRITE, 32'(k) << 9, 32'hC0DE_0000 + k);
        for (int unsigned k = 1; k <= 6; k++)
            send_access(OP_READ, 32'(k) << 9, 32'h0);
        send_access(OP_READ, 32'h0, 32'h0);
        send_access(OP_WRITE, 32'h8000_0000, 32'h0);
        send_access(OP_READ, 32'h8000_0000, 32'h0);
    endtask

    // illegal values and the unused index must change nothing
    task automatic test_ignored_writes();
        go_idle();
        write_reg(CFG_CAPACITY, 3);
        write_reg(CFG_CAPACITY, 127);
        write_reg(CFG_BLOCK, 12);
        write_reg(CFG_WAYS, 3);
        write_reg(CFG_WAYS, 0);
        write_reg(CFG_NONE, 8);
        for (int unsigned k = 0; k < 6; k++) send_access(OP_READ, 32'(k) << 9, 32'h0);
    endtask

    task automatic set_geometry(input int unsigned c, input int unsigned b, input int unsigned w);
        go_idle();
        write_reg(CFG_CAPACITY, c);
        write_reg(CFG_BLOCK, b);
        write_reg(CFG_WAYS, w);
    endtask

    task automatic test_extreme_geometries();
        set_geometry(2, 64, 8);     // fewest sets, longest lines
        random_phase(170);
        set_geometry(64, 8, 1);     // most sets, direct mapped
        random_phase(170);
    endtask

    task automatic test_random_geometries();
        int unsigned caps[6] = '{2, 4, 8, 16, 32, 64};
        int unsigned blks[4] = '{8, 16, 32, 64};
        int unsigned wys[4]  = '{1, 2, 4, 8};
        for (int p = 0; p < 4; p++) begin
            set_geometry(caps[$urandom_range(0, 5)], blks[$urandom_range(0, 3)],
                         wys[$urandom_range(0, 3)]);
            random_phase(60);
            // sender holds off until the unit has emptied
            i_in_valid <= 1'b0;
            wait (expected_results.size() == 0);
            @(posedge i_clk);
            random_phase(60);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: read_word=%h hit=%b", o_read_word, o_hit);
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                n_hits += e.hit;
                if (o_read_word !== e.read_word) begin
                    $error("read_word: expected %h, actual %h", e.read_word, o_read_word);
                    n_errors++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit: expected %b, actual %b", e.hit, o_hit);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalls a random number of cycles per result
    initial begin
        int unsigned n;
        @(posedge i_rst_n);
        forever begin
            n = idle_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            if (idle_gap() > 0) i_out_stall <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        n_errors = 0; n_sent = 0; n_checked = 0; n_hits = 0; n_cfg = 0;
        no_idle = 1'b0;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_ignored_writes();
        test_extreme_geometries();
        test_random_geometries();
        go_idle();
        $display("Covered %0d accesses (%0d hits) over %0d register writes, %0d results checked.",
                 n_sent, n_hits, n_cfg, n_checked);
        if (n_errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
